>>> rtl/ratio_of_uniforms_normal_test_unit_macros.svh
// Assertion macros for the ratio-of-uniforms normal test unit.
// Used by the top level; needs signals named clk and arst_n in scope.
`ifndef RATIO_OF_UNIFORMS_NORMAL_TEST_UNIT_MACROS_SVH
`define RATIO_OF_UNIFORMS_NORMAL_TEST_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define ROUN_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("roun assertion failed");
// Next-cycle implication, checked outside reset.
`define ROUN_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("roun assertion failed");
`else
`define ROUN_ASSERT_IMP(lbl, ante, cons)
`define ROUN_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/roun_pkg.sv
// Shared constants and types of the ratio-of-uniforms normal test unit.
// No dependencies.
`timescale 1ns / 1ps
package roun_pkg;
	// Result sample width.
	localparam int SAMPLE_W = 32;

	// Unsigned Q0.32 constants.
	localparam logic [31:0] K_SQRT2E = 32'd3684067834; // sqrt(2/e)
	localparam logic [31:0] K_EXP135 = 32'd1113428441; // exp(-1.35)
	localparam logic [31:0] K_035    = 32'd1503238554; // 0.35
	localparam logic [31:0] K_LN2    = 32'd2977044472; // ln 2

	// Which test decided the outcome.
	typedef enum logic [1:0] {
		DEC_QUICK_ACC = 2'd0,
		DEC_QUICK_REJ = 2'd1,
		DEC_LOG_ACC   = 2'd2,
		DEC_LOG_REJ   = 2'd3
	} decide_t;
endpackage

>>> rtl/roun_in_if.sv
// Input stream interface: one pair of uniform integers per transfer.
// No dependencies.
`timescale 1ns / 1ps
interface roun_in_if #(parameter int UNIFORM_BITS = 31) ();
	logic                    valid;
	logic                    ready;
	logic [UNIFORM_BITS-1:0] uniform_a;
	logic [UNIFORM_BITS-1:0] uniform_b;

	modport source (output valid, uniform_a, uniform_b, input ready);
	modport sink (input valid, uniform_a, uniform_b, output ready);
endinterface

>>> rtl/roun_out_if.sv
// Result stream interface: one candidate sample and its verdict per transfer.
// Depends on roun_pkg.
`timescale 1ns / 1ps
interface roun_out_if import roun_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic                       accepted;
	decide_t                    decided_by;

	modport source (output valid, sample_value, accepted, decided_by, input ready);
	modport sink (input valid, sample_value, accepted, decided_by, output ready);
endinterface

>>> rtl/ratio_of_uniforms_normal_test_unit.sv
// Ratio-of-uniforms normal sampler test with squeeze tests, fully pipelined.
// Depends on roun_pkg, roun_in_if, roun_out_if and the assertion macro header.
//
// One uniform pair is taken in every clock cycle while the output is not stalled,
// and each pair yields one result. The depth of the pipeline is set by the
// restoring divider that forms |x|, one quotient bit per stage over UNIFORM_BITS+32
// stages; the 32-step log2 squaring runs alongside it. All stages advance together
// and hold while a finished result waits, so ready on the input follows ready on
// the output in the same cycle.
`timescale 1ns / 1ps
`include "ratio_of_uniforms_normal_test_unit_macros.svh"
module ratio_of_uniforms_normal_test_unit import roun_pkg::*; #(
	parameter int UNIFORM_BITS  = 31,
	parameter int FRACTION_BITS = 26
) (
	input logic          clk,
	input logic          arst_n,
	roun_in_if.sink      uniforms,
	roun_out_if.source   result
);
	localparam int UB   = UNIFORM_BITS;
	localparam int AW   = UB + 1;            // width of A = 2a+1
	localparam int QW   = UB + 32;           // width of dividend and quotient
	localparam int PW   = $clog2(AW);        // top-bit index of A
	localparam int HW   = $clog2(AW + 1);    // integer part of log2 term
	localparam int LAT  = QW + 7;            // total pipeline depth
	localparam int SH_L = (FRACTION_BITS >= 31) ? FRACTION_BITS - 31 : 0;
	localparam int SH_R = (FRACTION_BITS < 31) ? 31 - FRACTION_BITS : 0;
	localparam int U1SH = 32 - UB;

	logic           en;
	logic [LAT-1:0] vld_s;

	// The whole pipeline advances unless the output holds an untaken result.
	assign en = !vld_s[LAT-1] || result.ready;
	assign uniforms.ready = en;
	assign result.valid = vld_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], uniforms.valid};
		end
	end

	// Stage 1: odd integers A and B, magnitude of B - 2^UB, log normalization.
	logic [AW-1:0] a_full, b_full, half_c;
	logic          neg_c;
	logic [UB-1:0] nmag_c;
	logic [PW-1:0] top_c;
	logic [31:0]   mant_c;
	logic [63:0]   a64_c;
	logic [5:0]    lsh_c;

	always_comb begin
		a_full = {uniforms.uniform_a, 1'b1};
		b_full = {uniforms.uniform_b, 1'b1};
		half_c = {1'b1, {UB{1'b0}}};
		neg_c  = !uniforms.uniform_b[UB-1];
		nmag_c = neg_c ? UB'(half_c - b_full) : UB'(b_full - half_c);
		top_c  = '0;
		for (int i = 0; i < AW; i++) begin
			if (a_full[i]) begin
				top_c = PW'(i);
			end
		end
		a64_c = 64'(a_full);
		lsh_c = 6'd31 - 6'(top_c);
		if (6'(top_c) > 6'd31) begin
			mant_c = 32'(a64_c >> 1);
		end else begin
			mant_c = 32'(a64_c << lsh_c);
		end
	end

	logic [AW-1:0] a_s1;
	logic          neg_s1;
	logic [UB-1:0] nmag_s1;
	logic [31:0]   lg_m_s [33];
	logic [PW-1:0] lg_p_s [33];
	logic [31:0]   lg_f_s [33];

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1      <= a_full;
			neg_s1    <= neg_c;
			nmag_s1   <= nmag_c;
			lg_m_s[0] <= mant_c;
			lg_p_s[0] <= top_c;
			lg_f_s[0] <= '0;
		end
	end

	// Stage 2: dividend sqrt(2/e) * |N|.
	logic [QW-1:0] div_dvd_s [QW+1];
	logic [QW-1:0] div_quo_s [QW+1];
	logic [AW-1:0] div_rem_s [QW+1];
	logic [AW-1:0] div_a_s   [QW+1];
	logic          div_neg_s [QW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			div_dvd_s[0] <= QW'(QW'(K_SQRT2E) * QW'(nmag_s1));
			div_quo_s[0] <= '0;
			div_rem_s[0] <= '0;
			div_a_s[0]   <= a_s1;
			div_neg_s[0] <= neg_s1;
		end
	end

	// Restoring division by A, one quotient bit per stage, MSB first.
	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [AW:0]   trial;
		logic          take;
		logic [AW-1:0] rem_nx;

		always_comb begin
			trial  = {div_rem_s[j], div_dvd_s[j][QW-1-j]};
			take   = trial >= {1'b0, div_a_s[j]};
			rem_nx = take ? AW'(trial - {1'b0, div_a_s[j]}) : trial[AW-1:0];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_dvd_s[j+1] <= div_dvd_s[j];
				div_quo_s[j+1] <= {div_quo_s[j][QW-2:0], take};
				div_rem_s[j+1] <= rem_nx;
				div_a_s[j+1]   <= div_a_s[j];
				div_neg_s[j+1] <= div_neg_s[j];
			end
		end
	end

	// Log2 fraction of the mantissa: square, and shift out one bit per stage.
	for (genvar k = 0; k < 32; k++) begin : g_log
		logic [63:0] sq;
		logic [32:0] sh;

		always_comb begin
			sq = 64'(lg_m_s[k]) * 64'(lg_m_s[k]);
			sh = sq[63:31];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lg_m_s[k+1] <= sh[32] ? sh[32:1] : sh[31:0];
				lg_f_s[k+1] <= {lg_f_s[k][30:0], sh[32]};
				lg_p_s[k+1] <= lg_p_s[k];
			end
		end
	end

	// Stages 34 to 36: -ln(u1) = ((AW - p) - frac) * ln 2 in Q32.
	logic [HW+31:0] lg_l2_s34;
	logic [63:0]    lg_pl_s35;
	logic [HW+31:0] lg_ph_s35;
	logic [HW+32:0] neglog_s36;
	logic [HW+32:0] nl_dly_s [UB];

	always_ff @(posedge clk) begin
		if (en) begin
			lg_l2_s34  <= {HW'(AW) - HW'(lg_p_s[32]), 32'd0} - (HW+32)'(lg_f_s[32]);
			lg_pl_s35  <= 64'(lg_l2_s34[31:0]) * 64'(K_LN2);
			lg_ph_s35  <= (HW+32)'((HW+32)'(lg_l2_s34[HW+31:32]) * (HW+32)'(K_LN2));
			neglog_s36 <= (HW+33)'(lg_pl_s35[63:32]) + (HW+33)'(lg_ph_s35);
			nl_dly_s[0] <= neglog_s36;
		end
	end

	// Delay line that lines the log result up with w.
	for (genvar d = 1; d < UB; d++) begin : g_nl_dly
		always_ff @(posedge clk) begin
			if (en) begin
				nl_dly_s[d] <= nl_dly_s[d-1];
			end
		end
	end

	// Tail stage 1: partial squares of |x| and the saturated output value.
	logic [63:0] xm64;
	logic [63:0] mag;
	logic [31:0] outv_c;

	always_comb begin
		xm64 = 64'(div_quo_s[QW]);
		if (FRACTION_BITS >= 31) begin
			if (xm64 > (64'hFFFF_FFFF >> SH_L)) begin
				mag = 64'h1_0000_0000;
			end else begin
				mag = xm64 << SH_L;
			end
		end else begin
			mag = xm64 >> SH_R;
		end
		if (div_neg_s[QW]) begin
			if (mag > 64'h8000_0000) begin
				mag = 64'h8000_0000;
			end
			outv_c = 32'(64'd0 - mag);
		end else begin
			if (mag > 64'h7FFF_FFFF) begin
				mag = 64'h7FFF_FFFF;
			end
			outv_c = mag[31:0];
		end
	end

	logic          sat_st1;
	logic [47:0]   pll_st1, plh_st1, phh_st1;
	logic [AW-1:0] a_st1;
	logic [31:0]   outv_st1;

	always_ff @(posedge clk) begin
		if (en) begin
			sat_st1  <= |xm64[63:48];
			pll_st1  <= 48'(xm64[23:0]) * 48'(xm64[23:0]);
			plh_st1  <= 48'(xm64[23:0]) * 48'(xm64[47:24]);
			phh_st1  <= 48'(xm64[47:24]) * 48'(xm64[47:24]);
			a_st1    <= div_a_s[QW];
			outv_st1 <= outv_c;
		end
	end

	// Tail stage 2: w = |x|^2 / 4 in Q32, saturated.
	logic [95:0]   sq96;
	logic [63:0]   w_st2;
	logic [AW-1:0] a_st2;
	logic [31:0]   outv_st2;

	assign sq96 = ({48'd0, phh_st1} << 48) + ({48'd0, plh_st1} << 25) + {48'd0, pll_st1};

	always_ff @(posedge clk) begin
		if (en) begin
			w_st2    <= sat_st1 ? '1 : sq96[95:32];
			a_st2    <= a_st1;
			outv_st2 <= outv_st1;
		end
	end

	// Tail stage 3: quick accept, log compare and the offset w - 0.35.
	// A w of 2^33 or more can never pass quick accept, since 2^33 - u1 < 2^33.
	logic [32:0] u1_c;
	logic [33:0] dlim_c;

	always_comb begin
		u1_c   = 33'(a_st2) << U1SH;
		dlim_c = 34'h2_0000_0000 - 34'(u1_c);
	end

	logic          qa_st3, ge_st3, le_st3;
	logic [63:0]   d_st3;
	logic [AW-1:0] a_st3;
	logic [31:0]   outv_st3;

	always_ff @(posedge clk) begin
		if (en) begin
			qa_st3   <= (w_st2 < 64'h2_0000_0000) && ({w_st2[32:0], 1'b0} <= dlim_c);
			ge_st3   <= w_st2 >= 64'(K_035);
			le_st3   <= w_st2 <= 64'(nl_dly_s[UB-1]);
			d_st3    <= w_st2 - 64'(K_035);
			a_st3    <= a_st2;
			outv_st3 <= outv_st2;
		end
	end

	// Tail stage 4: (w - 0.35) * u1 as two partial products.
	logic [32:0] u1_st3;
	logic [64:0] p0_st4, p1_st4;
	logic        qa_st4, ge_st4, le_st4;
	logic [31:0] outv_st4;

	assign u1_st3 = 33'(a_st3) << U1SH;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_st4   <= 65'(d_st3[31:0]) * 65'(u1_st3);
			p1_st4   <= 65'(d_st3[63:32]) * 65'(u1_st3);
			qa_st4   <= qa_st3;
			ge_st4   <= ge_st3;
			le_st4   <= le_st3;
			outv_st4 <= outv_st3;
		end
	end

	// Tail stage 5: quick reject compare and the verdict.
	logic [96:0] rej_sum;
	logic        qrej_c;
	logic        acc_c;
	decide_t     how_c;

	always_comb begin
		rej_sum = ({32'd0, p1_st4} << 32) + {32'd0, p0_st4};
		qrej_c  = ge_st4 && (rej_sum > 97'({K_EXP135, 33'd0}));
		if (qa_st4) begin
			acc_c = 1'b1;
			how_c = DEC_QUICK_ACC;
		end else if (qrej_c) begin
			acc_c = 1'b0;
			how_c = DEC_QUICK_REJ;
		end else if (le_st4) begin
			acc_c = 1'b1;
			how_c = DEC_LOG_ACC;
		end else begin
			acc_c = 1'b0;
			how_c = DEC_LOG_REJ;
		end
	end

	logic [31:0] outv_st5;
	logic        acc_st5;
	decide_t     how_st5;

	always_ff @(posedge clk) begin
		if (en) begin
			outv_st5 <= outv_st4;
			acc_st5  <= acc_c;
			how_st5  <= how_c;
		end
	end

	assign result.sample_value = $signed(outv_st5);
	assign result.accepted     = acc_st5;
	assign result.decided_by   = how_st5;

	// Checks on the division, the verdict encoding and the stall path.
	`ROUN_ASSERT_IMP(a_div_rem, vld_s[QW+1], div_rem_s[QW] < div_a_s[QW])
	`ROUN_ASSERT_IMP(a_verdict, result.valid,
		result.accepted == (result.decided_by == DEC_QUICK_ACC ||
		result.decided_by == DEC_LOG_ACC))
	`ROUN_ASSERT_IMP(a_stall, result.valid && !result.ready, !uniforms.ready)
	`ROUN_ASSERT_NXT(a_enter, uniforms.valid && uniforms.ready, vld_s[0])
endmodule
